// ===== sv/ssm_pkg.sv =====
// ssm_pkg: shared codes and constants for sorted_stack_merge
// no dependencies
`default_nettype none

package ssm_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;
    typedef logic signed [31:0] word_t;

    localparam mode_t MODE_PUSH_A = 2'd0;
    localparam mode_t MODE_PUSH_B = 2'd1;
    localparam mode_t MODE_MERGE  = 2'd2;
    localparam mode_t MODE_CLEAR  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // most results one merge transaction emits
    localparam int MAX_RESULTS = 32;
    localparam int OUT_CNT_W   = 6;
    localparam int CAP_MAX     = 32;

endpackage

`default_nettype wire

// ===== sv/sorted_stack_merge.sv =====
// sorted_stack_merge: two bounded stacks merged into one sequence, largest first
// depends on ssm_pkg
//
// A request transaction carries mode and value. Push onto stack A or B, and
// clear, each give one result (status full when a push is dropped). A merge
// pops the smaller of the two stack tops (A on a tie) into the merged store,
// one element per cycle through a single signed comparator, then reads the
// store back one entry at a time (registered memory read, then output load,
// which waits for a free output register), largest first, at most 32
// results, last set on the final one. A merge of two empty stacks gives one
// result with status nothing-to-merge. The block takes a new request only
// when the sequencer is idle and the output register is free or being emptied.
`default_nettype none

module sorted_stack_merge
    import ssm_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [1:0]          mode,
    input  wire logic signed [31:0]  value,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic signed [31:0]       value_res,
    output logic [1:0]               status,
    output logic                     last
);

    // capacity clamped to the legal range
    localparam int CAP     = (STACK_DEPTH < 1) ? 1 :
                             ((STACK_DEPTH > CAP_MAX) ? CAP_MAX : STACK_DEPTH);
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam int ADDR_W  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int MDEPTH  = 2 * CAP;
    localparam int MCNT_W  = $clog2(MDEPTH + 1);
    localparam int MADDR_W = $clog2(MDEPTH);
    localparam int TOT_W   = MCNT_W + OUT_CNT_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MERGE = 2'd1;
    localparam logic [1:0] S_RD    = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0] state_reg, state_next;

    // stacks: written at the push slot, read only at the top
    word_t stack_a_mem [CAP];
    word_t stack_b_mem [CAP];
    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0] b_cnt_reg, b_cnt_next;
    logic             a_we, b_we;

    // merged store, ascending; registered read port
    word_t merged_mem [MDEPTH];
    logic [MCNT_W-1:0]    m_cnt_reg, m_cnt_next;
    logic                 m_we;
    word_t                m_wdata;
    logic                 m_re;
    word_t                m_rd_data_reg;
    logic [MADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [OUT_CNT_W-1:0] remain_reg, remain_next;

    // output register
    logic    res_valid_reg, res_valid_next;
    word_t   value_res_reg, value_res_next;
    status_t status_reg, status_next;
    logic    last_reg, last_next;
    logic    out_load;
    logic    out_free;

    logic             accept;
    logic             a_nz, b_nz, a_full, b_full;
    word_t            top_a, top_b;
    logic             take_a;
    logic [CNT_W:0]   both_cnt;
    logic [TOT_W-1:0] tot_ext;

    assign out_free  = !res_valid_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    assign a_nz   = (a_cnt_reg != '0);
    assign b_nz   = (b_cnt_reg != '0);
    assign a_full = (a_cnt_reg >= CNT_W'(CAP));
    assign b_full = (b_cnt_reg >= CNT_W'(CAP));

    // top of each stack, only looked at while the stack is not empty
    assign top_a = stack_a_mem[ADDR_W'(a_cnt_reg - CNT_W'(1))];
    assign top_b = stack_b_mem[ADDR_W'(b_cnt_reg - CNT_W'(1))];

    // the shared comparator: A wins a tie, an empty side never wins
    assign take_a   = a_nz && (!b_nz || (top_a <= top_b));
    assign both_cnt = {1'b0, a_cnt_reg} + {1'b0, b_cnt_reg};
    assign tot_ext  = TOT_W'(m_cnt_reg) + TOT_W'(1);
    assign m_wdata  = take_a ? top_a : top_b;

    always_comb
    begin
        state_next     = state_reg;
        a_cnt_next     = a_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        m_cnt_next     = m_cnt_reg;
        m_we           = 1'b0;
        m_re           = 1'b0;
        rd_addr_next   = rd_addr_reg;
        remain_next    = remain_reg;
        out_load       = 1'b0;
        value_res_next = '0;
        status_next    = ST_OK;
        last_next      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_PUSH_A:
                        begin
                            out_load = 1'b1;
                            if (a_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + CNT_W'(1);
                            end
                        end
                        MODE_PUSH_B:
                        begin
                            out_load = 1'b1;
                            if (b_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + CNT_W'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            out_load   = 1'b1;
                            a_cnt_next = '0;
                            b_cnt_next = '0;
                        end
                        MODE_MERGE:
                        begin
                            if (!a_nz && !b_nz)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                m_cnt_next = '0;
                                state_next = S_MERGE;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_MERGE:
            begin
                // one pop per cycle into the merged store
                m_we       = 1'b1;
                m_cnt_next = m_cnt_reg + MCNT_W'(1);
                if (take_a)
                begin
                    a_cnt_next = a_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    b_cnt_next = b_cnt_reg - CNT_W'(1);
                end
                if (both_cnt == (CNT_W + 1)'(1))
                begin
                    // this was the last element: read back from the newest entry
                    state_next   = S_RD;
                    rd_addr_next = MADDR_W'(m_cnt_reg);
                    remain_next  = (tot_ext > TOT_W'(MAX_RESULTS)) ?
                                   OUT_CNT_W'(MAX_RESULTS) : tot_ext[OUT_CNT_W-1:0];
                end
            end
            S_RD:
            begin
                m_re       = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    value_res_next = m_rd_data_reg;
                    last_next      = (remain_reg == OUT_CNT_W'(1));
                    if (remain_reg == OUT_CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next  = remain_reg - OUT_CNT_W'(1);
                        rd_addr_next = rd_addr_reg - MADDR_W'(1);
                        state_next   = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            m_cnt_reg     <= '0;
            res_valid_reg <= 1'b0;
            remain_reg    <= '0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            m_cnt_reg     <= m_cnt_next;
            res_valid_reg <= res_valid_next;
            remain_reg    <= remain_next;
            rd_addr_reg   <= rd_addr_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_res_reg <= value_res_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    // stack storage
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            stack_a_mem[ADDR_W'(a_cnt_reg)] <= value;
        end
        if (b_we)
        begin
            stack_b_mem[ADDR_W'(b_cnt_reg)] <= value;
        end
    end

    // merged store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            merged_mem[MADDR_W'(m_cnt_reg)] <= m_wdata;
        end
        if (m_re)
        begin
            m_rd_data_reg <= merged_mem[rd_addr_reg];
        end
    end

    assign res_valid = res_valid_reg;
    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // stack fill never passes the capacity
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_cnt_reg <= CNT_W'(CAP)) && (b_cnt_reg <= CNT_W'(CAP)))
        else $error("stack count beyond capacity");

    // a merge of non-empty stacks starts the pop sequence
    a_merge_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_MERGE) && (a_nz || b_nz)) |=> (state_reg == S_MERGE))
        else $error("merge did not start");

    // leaving the pop sequence means both stacks are drained
    a_merge_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MERGE) && (state_next != S_MERGE)) |=>
        ((a_cnt_reg == '0) && (b_cnt_reg == '0)))
        else $error("merge ended with stack elements left");

    // only merged elements come without last, always with ok status
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> (status == ST_OK))
        else $error("non-final result with error status");

endmodule

`default_nettype wire
